// File: src/bse_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bubble sort engine.
// No dependencies; every other file but bse_mem refers to it by scoped names.
package bse_pkg;

  localparam int VALUE_W = 32;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_RD,
    ST_PASS_LD,
    ST_PASS_CMP,
    ST_PASS_END,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  typedef enum logic [1:0] {
    WR_IN,
    WR_KEEP,
    WR_CUR
  } wr_src_t;

  typedef struct packed {
    logic    cur_load_mem;
    logic    cur_load_carry;
    logic    wr_en;
    wr_src_t wr_src;
    logic    out_load;
  } dp_ctrl_t;

endpackage

// File: src/bubble_sort_engine.sv
`timescale 1ns / 1ps
// Bubble sort engine: loads one element per cycle while in_stall is low, sorts in place,
// emits in order. Sort: one memory read and one shared compare-and-swap per cycle.
// Emit: each result takes a memory read, an output load and a handoff held by out_stall.
// Synchronous active-low reset clears sequencer, count, drop flag, output valid and
// direction; the element store and the overflow output are not cleared.
// Depends on bse_pkg, bse_ctrl, bse_cmp, bse_mem.
module bubble_sort_engine #(
  parameter int MAX_ITEMS     = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bse_pkg::VALUE_W-1:0] in_value,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bse_pkg::VALUE_W-1:0] out_sorted_value,
  output logic                        out_final_res,
  output logic                        out_overflow,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_descending
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  bse_pkg::dp_ctrl_t dp;
  logic                     desc;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic [ELEMENT_WIDTH-1:0] wr_data;
  logic [ELEMENT_WIDTH-1:0] rd_data;
  logic [ELEMENT_WIDTH-1:0] in_elem;
  logic [ELEMENT_WIDTH+bse_pkg::VALUE_W-1:0] in_wide;
  logic [ELEMENT_WIDTH+bse_pkg::VALUE_W-1:0] out_wide;
  logic [ELEMENT_WIDTH-1:0] val_r;
  logic [ELEMENT_WIDTH-1:0] val_nxt;

  assign in_wide = {{ELEMENT_WIDTH{1'b0}}, in_value};
  assign in_elem = in_wide[ELEMENT_WIDTH-1:0];

  bse_ctrl #(
    .MAX_ITEMS(MAX_ITEMS),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last       (in_last),
    .in_stall      (in_stall),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_final_res (out_final_res),
    .out_overflow  (out_overflow),
    .cfg_valid     (cfg_valid),
    .cfg_descending(cfg_descending),
    .cfg_ready     (cfg_ready),
    .desc          (desc),
    .dp            (dp),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr)
  );

  bse_cmp #(
    .WIDTH(ELEMENT_WIDTH)
  ) u_cmp (
    .clk    (clk),
    .dp     (dp),
    .desc   (desc),
    .rd_data(rd_data),
    .in_elem(in_elem),
    .wr_data(wr_data)
  );

  bse_mem #(
    .DEPTH(MAX_ITEMS),
    .WIDTH(ELEMENT_WIDTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (dp.wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign val_nxt = dp.out_load ? rd_data : val_r;

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign out_wide         = {{bse_pkg::VALUE_W{1'b0}}, val_r};
  assign out_sorted_value = out_wide[bse_pkg::VALUE_W-1:0];

  a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input accepted while a result is pending");

  a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> in_stall)
    else $error("input still open after the last request");

  a_final_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_final_res) |=> (!out_valid && !in_stall))
    else $error("block not idle after the final result");

endmodule

// File: src/bse_mem.sv
`timescale 1ns / 1ps
// Element store: one write port and one read port with registered read data.
// Uses no package items.
module bse_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/bse_cmp.sv
`timescale 1ns / 1ps
// Shared compare-and-swap unit with the carried element register of a pass.
// Depends on bse_pkg for the datapath control struct.
module bse_cmp #(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  bse_pkg::dp_ctrl_t dp,
  input  logic              desc,
  input  logic [WIDTH-1:0]  rd_data,
  input  logic [WIDTH-1:0]  in_elem,
  output logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] cur_r;
  logic [WIDTH-1:0] cur_nxt;
  logic             swap;
  logic [WIDTH-1:0] keep;
  logic [WIDTH-1:0] carry;

  assign swap  = desc ? (cur_r < rd_data) : (cur_r > rd_data);
  assign keep  = swap ? rd_data : cur_r;
  assign carry = swap ? cur_r : rd_data;

  always_comb begin
    cur_nxt = cur_r;
    if (dp.cur_load_mem) begin
      cur_nxt = rd_data;
    end else if (dp.cur_load_carry) begin
      cur_nxt = carry;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_comb begin
    unique case (dp.wr_src)
      bse_pkg::WR_IN:   wr_data = in_elem;
      bse_pkg::WR_KEEP: wr_data = keep;
      bse_pkg::WR_CUR:  wr_data = cur_r;
      default:          wr_data = in_elem;
    endcase
  end

endmodule

// File: src/bse_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: load, bubble passes, emit; counters, flags and handshakes.
// Depends on bse_pkg for the state enum and datapath control struct.
module bse_ctrl #(
  parameter int MAX_ITEMS = 64,
  parameter int AW        = 6,
  parameter int CW        = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              out_final_res,
  output logic              out_overflow,
  input  logic              cfg_valid,
  input  logic              cfg_descending,
  output logic              cfg_ready,
  output logic              desc,
  output bse_pkg::dp_ctrl_t dp,
  output logic [AW-1:0]     wr_addr,
  output logic [AW-1:0]     rd_addr
);

  bse_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            drop_r, drop_nxt;
  logic [CW-1:0]   lim_r, lim_nxt;
  logic [AW-1:0]   j_r, j_nxt;
  logic [AW-1:0]   k_r, k_nxt;
  logic            desc_r, desc_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic            final_r, final_nxt;
  logic            ovf_r, ovf_nxt;

  logic            in_fire;
  logic            out_fire;
  logic            full;
  logic [CW-1:0]   count_inc;
  logic [CW-1:0]   j2;
  logic [CW-1:0]   k1;
  logic            pass_more;
  logic            next_pass;

  assign in_fire   = in_valid && (state_r == bse_pkg::ST_LOAD);
  assign out_fire  = ovalid_r && !out_stall;
  assign full      = (count_r == CW'(MAX_ITEMS));
  assign count_inc = full ? count_r : count_r + CW'(1);
  assign j2        = CW'(j_r) + CW'(2);
  assign k1        = CW'(k_r) + CW'(1);
  assign pass_more = (j2 < lim_r);
  assign next_pass = ((lim_r - CW'(1)) >= CW'(2));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bse_pkg::ST_LOAD: begin
        if (in_fire && in_last) begin
          state_nxt = (count_inc >= CW'(2)) ? bse_pkg::ST_PASS_RD : bse_pkg::ST_EMIT_RD;
        end
      end
      bse_pkg::ST_PASS_RD:  state_nxt = bse_pkg::ST_PASS_LD;
      bse_pkg::ST_PASS_LD:  state_nxt = bse_pkg::ST_PASS_CMP;
      bse_pkg::ST_PASS_CMP: state_nxt = pass_more ? bse_pkg::ST_PASS_CMP
                                                  : bse_pkg::ST_PASS_END;
      bse_pkg::ST_PASS_END: state_nxt = next_pass ? bse_pkg::ST_PASS_LD
                                                  : bse_pkg::ST_EMIT_RD;
      bse_pkg::ST_EMIT_RD:  state_nxt = bse_pkg::ST_EMIT_LD;
      bse_pkg::ST_EMIT_LD:  state_nxt = bse_pkg::ST_EMIT_WAIT;
      bse_pkg::ST_EMIT_WAIT: begin
        if (out_fire) begin
          state_nxt = final_r ? bse_pkg::ST_LOAD : bse_pkg::ST_EMIT_RD;
        end
      end
      default: state_nxt = bse_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    count_nxt         = count_r;
    drop_nxt          = drop_r;
    lim_nxt           = lim_r;
    j_nxt             = j_r;
    k_nxt             = k_r;
    desc_nxt          = desc_r;
    ovalid_nxt        = ovalid_r;
    final_nxt         = final_r;
    ovf_nxt           = ovf_r;
    dp.cur_load_mem   = 1'b0;
    dp.cur_load_carry = 1'b0;
    dp.wr_en          = 1'b0;
    dp.wr_src         = bse_pkg::WR_IN;
    dp.out_load       = 1'b0;
    wr_addr           = j_r;
    rd_addr           = '0;
    unique case (state_r)
      bse_pkg::ST_LOAD: begin
        wr_addr = count_r[AW-1:0];
        if (cfg_valid) begin
          desc_nxt = cfg_descending;
        end
        if (in_fire) begin
          dp.wr_en  = !full;
          count_nxt = count_inc;
          drop_nxt  = drop_r | full;
          if (in_last) begin
            lim_nxt = count_inc;
            j_nxt   = '0;
            k_nxt   = '0;
          end
        end
      end
      bse_pkg::ST_PASS_RD: begin
        rd_addr = '0;
      end
      bse_pkg::ST_PASS_LD: begin
        dp.cur_load_mem = 1'b1;
        rd_addr         = AW'(1);
        j_nxt           = '0;
      end
      bse_pkg::ST_PASS_CMP: begin
        dp.cur_load_carry = 1'b1;
        dp.wr_en          = 1'b1;
        dp.wr_src         = bse_pkg::WR_KEEP;
        rd_addr           = pass_more ? j2[AW-1:0] : '0;
        j_nxt             = j_r + AW'(1);
      end
      bse_pkg::ST_PASS_END: begin
        dp.wr_en  = 1'b1;
        dp.wr_src = bse_pkg::WR_CUR;
        rd_addr   = '0;
        lim_nxt   = lim_r - CW'(1);
        k_nxt     = '0;
      end
      bse_pkg::ST_EMIT_RD: begin
        rd_addr = k_r;
      end
      bse_pkg::ST_EMIT_LD: begin
        dp.out_load = 1'b1;
        ovalid_nxt  = 1'b1;
        final_nxt   = (k1 == count_r);
        ovf_nxt     = drop_r;
      end
      bse_pkg::ST_EMIT_WAIT: begin
        if (out_fire) begin
          ovalid_nxt = 1'b0;
          k_nxt      = k_r + AW'(1);
          if (final_r) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
          end
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bse_pkg::ST_LOAD;
      count_r  <= '0;
      drop_r   <= 1'b0;
      desc_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      drop_r   <= drop_nxt;
      desc_r   <= desc_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r   <= lim_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    final_r <= final_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign in_stall      = (state_r != bse_pkg::ST_LOAD);
  assign cfg_ready     = (state_r == bse_pkg::ST_LOAD);
  assign desc          = desc_r;
  assign out_valid     = ovalid_r;
  assign out_final_res = final_r;
  assign out_overflow  = ovf_r;

endmodule
